[hdl/piecewise_trajectory_eval_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the trajectory evaluator
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_TRAJECTORY_EVAL_UNIT_ASSERT_SVH
`define PIECEWISE_TRAJECTORY_EVAL_UNIT_ASSERT_SVH

// same-cycle implication
`define PTEV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTEV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ptev_pkg.sv]
// ----------------------------------------------------------------------------
// ptev_pkg
// Shared widths, codes and types of the trajectory evaluator.
// ----------------------------------------------------------------------------
package ptev_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int AXES         = 3;
  localparam int SEG_W        = 4;
  localparam int AX_W         = 2;
  localparam int CFG_W        = 5;
  localparam int TIME_W       = 48;
  localparam int COEF_W       = 32;
  localparam int COEF_DEPTH   = MAX_SEGMENTS * AXES;
  localparam int COEF_AW      = $clog2(COEF_DEPTH);
  localparam int MUL_W        = 33;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 96;
  localparam int FRAC_SH      = 33;

  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC_SH - 1);

  localparam logic          OP_LOAD    = 1'b0;
  localparam logic          OP_QUERY   = 1'b1;
  localparam logic [AX_W-1:0] AX_X     = 2'd0;
  localparam logic [AX_W-1:0] AX_Y     = 2'd1;
  localparam logic [AX_W-1:0] AX_Z     = 2'd2;
  localparam logic [AX_W-1:0] AX_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SQUARE,
    ST_AXIS,
    ST_FINISH
  } ptev_state_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_17,
    SH_32
  } acc_sh_t;

  typedef struct packed {
    logic    load;
    logic    add;
    acc_sh_t sh;
  } acc_ctl_t;

endpackage

[hdl/ptev_seg_table.sv]
// ----------------------------------------------------------------------------
// ptev_seg_table
// Segment time memory and coefficient memory, registered reads.
// ----------------------------------------------------------------------------
module ptev_seg_table (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ptev_pkg::SEG_W-1:0]        wr_seg,
  input  logic [ptev_pkg::AX_W-1:0]         wr_axis,
  input  logic [2*ptev_pkg::TIME_W-1:0]     wr_times,
  input  logic [3*ptev_pkg::COEF_W-1:0]     wr_coefs,
  input  logic [ptev_pkg::SEG_W-1:0]        tt_addr,
  output logic [2*ptev_pkg::TIME_W-1:0]     tt_q,
  input  logic [ptev_pkg::COEF_AW-1:0]      cf_addr,
  output logic [3*ptev_pkg::COEF_W-1:0]     cf_q
);
  import ptev_pkg::*;

  logic [2*TIME_W-1:0] time_mem [MAX_SEGMENTS];
  logic [3*COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [COEF_AW-1:0]  cf_wr_addr;

  assign cf_wr_addr = COEF_AW'(wr_seg) * COEF_AW'(AXES) + COEF_AW'(wr_axis);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_seg]     <= wr_times;
      coef_mem[cf_wr_addr] <= wr_coefs;
    end
    tt_q <= time_mem[tt_addr];
    cf_q <= coef_mem[cf_addr];
  end

endmodule

[hdl/ptev_mac.sv]
// ----------------------------------------------------------------------------
// ptev_mac
// Shared multiplier with a wide accumulator and round/saturate output.
// ----------------------------------------------------------------------------
module ptev_mac (
  input  logic                               clk,
  input  logic signed [ptev_pkg::MUL_W-1:0]  op_a,
  input  logic signed [ptev_pkg::MUL_W-1:0]  op_b,
  input  ptev_pkg::acc_ctl_t                 ctl,
  input  logic signed [ptev_pkg::COEF_W-1:0] init_pos,
  output logic [2*ptev_pkg::COEF_W-1:0]      prod_lo,
  output logic signed [ptev_pkg::COEF_W-1:0] result
);
  import ptev_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-1:0]         rsum;
  logic                     fits;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign prod_lo  = prod_r[2*COEF_W-1:0];

  always_comb begin
    case (ctl.sh)
      SH_0:    term = prod_ext;
      SH_17:   term = prod_ext <<< 17;
      SH_32:   term = prod_ext <<< 32;
      default: term = prod_ext;
    endcase
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = {{(ACC_W-COEF_W-FRAC_SH){init_pos[COEF_W-1]}}, init_pos, {FRAC_SH{1'b0}}};
    end else if (ctl.add) begin
      acc_nxt = acc_r + term;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
  end

  // round half up at bit 33, then clip to 32 bits
  assign rsum = acc_r + RND_BIAS;
  assign fits = (&rsum[ACC_W-1:FRAC_SH+COEF_W-1]) | ~(|rsum[ACC_W-1:FRAC_SH+COEF_W-1]);

  always_comb begin
    if (fits) begin
      result = rsum[FRAC_SH+COEF_W-1:FRAC_SH];
    end else if (rsum[ACC_W-1]) begin
      result = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

endmodule

[hdl/piecewise_trajectory_eval_unit.sv]
// Load item: written on accept, busy stays low, no result.
// Query item: the segment search reads one table entry a cycle up to the
// chosen segment, then a squaring step and per-axis steps run on the shared
// multiplier-accumulator for three axes before the result strobe.
// A new item may be started in the strobe cycle. Sync reset sets the segment
// count cfg_seg_r to 1; segment memories are not cleared.
// ----------------------------------------------------------------------------
// piecewise_trajectory_eval_unit
// Piecewise quadratic trajectory evaluator: segment search and sequencer.
// ----------------------------------------------------------------------------
`include "piecewise_trajectory_eval_unit_assert.svh"

module piecewise_trajectory_eval_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ptev_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_operation,
  input  logic [ptev_pkg::SEG_W-1:0]         in_seg_index,
  input  logic [ptev_pkg::AX_W-1:0]          in_axis,
  input  logic [ptev_pkg::TIME_W-1:0]        in_start_time,
  input  logic [ptev_pkg::TIME_W-1:0]        in_end_time,
  input  logic signed [ptev_pkg::COEF_W-1:0] in_accel,
  input  logic signed [ptev_pkg::COEF_W-1:0] in_velocity,
  input  logic signed [ptev_pkg::COEF_W-1:0] in_position,
  input  logic [ptev_pkg::TIME_W-1:0]        in_query_time,
  output logic                               out_valid,
  output logic signed [ptev_pkg::COEF_W-1:0] out_pos_x,
  output logic signed [ptev_pkg::COEF_W-1:0] out_pos_y,
  output logic signed [ptev_pkg::COEF_W-1:0] out_pos_z,
  output logic [ptev_pkg::SEG_W-1:0]         out_segment_used,
  output logic                               out_extrapolated
);
  import ptev_pkg::*;

  ptev_state_t              state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_seg_r;
  logic [TIME_W-1:0]        qt_r, qt_nxt;
  logic [SEG_W-1:0]         last_r, last_nxt;
  logic [SEG_W-1:0]         srch_r, srch_nxt;
  logic                     chk_r, chk_nxt;
  logic [SEG_W-1:0]         sel_r, sel_nxt;
  logic                     ext_r, ext_nxt;
  logic signed [COEF_W-1:0] d_r, d_nxt;
  logic [2*COEF_W-1:0]      sq_r, sq_nxt;
  logic [AX_W-1:0]          ax_r, ax_nxt;
  logic [1:0]               step_r, step_nxt;
  logic signed [COEF_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [COEF_W-1:0] pos_y_r, pos_y_nxt;
  logic signed [COEF_W-1:0] pos_z_r, pos_z_nxt;
  logic [SEG_W-1:0]         seg_out_r, seg_out_nxt;
  logic                     ext_out_r, ext_out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic                     accept;
  logic                     wr_en;
  logic [2*TIME_W-1:0]      tt_q;
  logic [3*COEF_W-1:0]      cf_q;
  logic [COEF_AW-1:0]       cf_addr;
  logic [AX_W-1:0]          rd_ax;
  logic [SEG_W-1:0]         chk_idx;
  logic                     hit;
  logic signed [TIME_W:0]   diff;
  logic signed [COEF_W-1:0] d_sat;
  logic signed [MUL_W-1:0]  op_a, op_b;
  acc_ctl_t                 acc_ctl;
  logic [2*COEF_W-1:0]      prod_lo;
  logic signed [COEF_W-1:0] mac_result;
  logic signed [COEF_W-1:0] cf_a, cf_v, cf_p;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (in_operation == OP_LOAD) && (in_axis != AX_NONE) &&
                  ({1'b0, in_seg_index} < (SEG_W+1)'(MAX_SEGMENTS));

  assign cf_a = cf_q[3*COEF_W-1:2*COEF_W];
  assign cf_v = cf_q[2*COEF_W-1:COEF_W];
  assign cf_p = cf_q[COEF_W-1:0];

  // prefetch next axis coefficients on the last step of an axis
  assign rd_ax   = (state_r == ST_AXIS && step_r == 2'd3 && ax_r != AX_Z) ?
                   ax_r + AX_W'(1) : ax_r;
  assign cf_addr = COEF_AW'(sel_r) * COEF_AW'(AXES) + COEF_AW'(rd_ax);

  ptev_seg_table u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_seg   (in_seg_index),
    .wr_axis  (in_axis),
    .wr_times ({in_start_time, in_end_time}),
    .wr_coefs ({in_accel, in_velocity, in_position}),
    .tt_addr  (srch_r),
    .tt_q     (tt_q),
    .cf_addr  (cf_addr),
    .cf_q     (cf_q)
  );

  ptev_mac u_mac (
    .clk      (clk),
    .op_a     (op_a),
    .op_b     (op_b),
    .ctl      (acc_ctl),
    .init_pos (cf_p),
    .prod_lo  (prod_lo),
    .result   (mac_result)
  );

  // tt_q holds the entry issued on the previous cycle
  assign chk_idx = srch_r - SEG_W'(1);
  assign hit     = (qt_r <= tt_q[TIME_W-1:0]);
  assign diff    = $signed({1'b0, qt_r}) - $signed({1'b0, tt_q[2*TIME_W-1:TIME_W]});

  always_comb begin
    if ((&diff[TIME_W:COEF_W-1]) | ~(|diff[TIME_W:COEF_W-1])) begin
      d_sat = diff[COEF_W-1:0];
    end else if (diff[TIME_W]) begin
      d_sat = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      d_sat = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    qt_nxt        = qt_r;
    last_nxt      = last_r;
    srch_nxt      = srch_r;
    chk_nxt       = chk_r;
    sel_nxt       = sel_r;
    ext_nxt       = ext_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    ax_nxt        = ax_r;
    step_nxt      = step_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    seg_out_nxt   = seg_out_r;
    ext_out_nxt   = ext_out_r;
    out_valid_nxt = 1'b0;
    op_a          = '0;
    op_b          = '0;
    acc_ctl       = '{load: 1'b0, add: 1'b0, sh: SH_0};

    case (state_r)
      ST_IDLE: begin
        if (accept && in_operation == OP_QUERY) begin
          qt_nxt   = in_query_time;
          srch_nxt = '0;
          chk_nxt  = 1'b0;
          if (cfg_seg_r == '0) begin
            last_nxt = '0;
          end else if (cfg_seg_r > CFG_W'(MAX_SEGMENTS)) begin
            last_nxt = SEG_W'(MAX_SEGMENTS - 1);
          end else begin
            last_nxt = SEG_W'(cfg_seg_r - CFG_W'(1));
          end
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        srch_nxt = srch_r + SEG_W'(1);
        chk_nxt  = 1'b1;
        if (chk_r && (hit || chk_idx == last_r)) begin
          sel_nxt   = chk_idx;
          ext_nxt   = !hit;
          d_nxt     = d_sat;
          ax_nxt    = AX_X;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        op_a      = {d_r[COEF_W-1], d_r};
        op_b      = {d_r[COEF_W-1], d_r};
        step_nxt  = '0;
        state_nxt = ST_AXIS;
      end
      ST_AXIS: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            op_a         = {cf_v[COEF_W-1], cf_v};
            op_b         = {d_r[COEF_W-1], d_r};
            acc_ctl.load = 1'b1;
            // accumulator still holds the previous axis here
            case (ax_r)
              AX_X:    sq_nxt    = prod_lo;
              AX_Y:    pos_x_nxt = mac_result;
              AX_Z:    pos_y_nxt = mac_result;
              default: sq_nxt    = sq_r;
            endcase
          end
          2'd1: begin
            op_a        = {cf_a[COEF_W-1], cf_a};
            op_b        = {1'b0, sq_r[COEF_W-1:0]};
            acc_ctl.add = 1'b1;
            acc_ctl.sh  = SH_17;
          end
          2'd2: begin
            op_a        = {cf_a[COEF_W-1], cf_a};
            op_b        = {1'b0, sq_r[2*COEF_W-1:COEF_W]};
            acc_ctl.add = 1'b1;
            acc_ctl.sh  = SH_0;
          end
          default: begin
            acc_ctl.add = 1'b1;
            acc_ctl.sh  = SH_32;
            if (ax_r == AX_Z) begin
              state_nxt = ST_FINISH;
            end else begin
              ax_nxt = ax_r + AX_W'(1);
            end
          end
        endcase
      end
      ST_FINISH: begin
        pos_z_nxt     = mac_result;
        seg_out_nxt   = sel_r;
        ext_out_nxt   = ext_r;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_seg_r   <= CFG_W'(1);
      out_valid_r <= 1'b0;
      chk_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      if (cfg_we) begin
        cfg_seg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    qt_r      <= qt_nxt;
    last_r    <= last_nxt;
    srch_r    <= srch_nxt;
    sel_r     <= sel_nxt;
    ext_r     <= ext_nxt;
    d_r       <= d_nxt;
    sq_r      <= sq_nxt;
    ax_r      <= ax_nxt;
    step_r    <= step_nxt;
    pos_x_r   <= pos_x_nxt;
    pos_y_r   <= pos_y_nxt;
    pos_z_r   <= pos_z_nxt;
    seg_out_r <= seg_out_nxt;
    ext_out_r <= ext_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_segment_used = seg_out_r;
  assign out_extrapolated = ext_out_r;

  `PTEV_ASSERT_NEXT(a_finish_strobe, state_r == ST_FINISH, out_valid && !busy, "finish without strobe")
  `PTEV_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `PTEV_ASSERT_NEXT(a_load_no_busy, accept && in_operation == OP_LOAD, !busy, "load item raised busy")
  `PTEV_ASSERT_NOW(a_extrap_last, out_valid && out_extrapolated, out_segment_used == last_r, "extrapolated item not on last segment")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trajectory evaluator. The table is filled from a
// planned set of segments, then directed and random load/query items run
// under several segment counts with random sender gaps. Every query is scored
// against an exact wide-integer evaluation of the quadratic.
// ----------------------------------------------------------------------------
module testbench;
  import ptev_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 8;
  localparam int RANDOM_ITEMS   = 85;
  localparam int C_ACC          = 0;
  localparam int C_VEL          = 1;
  localparam int C_POS          = 2;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
  localparam logic [TIME_W-1:0]        TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic                     op;
    logic [SEG_W-1:0]         slot;
    logic [AX_W-1:0]          ax;
    logic [TIME_W-1:0]        t0;
    logic [TIME_W-1:0]        t1;
    logic signed [COEF_W-1:0] acc;
    logic signed [COEF_W-1:0] vel;
    logic signed [COEF_W-1:0] pos;
    logic [TIME_W-1:0]        qt;
    logic                     drain;
  } traj_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] px;
    logic signed [COEF_W-1:0] py;
    logic signed [COEF_W-1:0] pz;
    logic [SEG_W-1:0]         seg;
    logic                     extra;
  } traj_point_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_W-1:0]          cfg_wdata = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_operation = 1'b0;
  logic [SEG_W-1:0]          in_seg_index = '0;
  logic [AX_W-1:0]           in_axis = '0;
  logic [TIME_W-1:0]         in_start_time = '0;
  logic [TIME_W-1:0]         in_end_time = '0;
  logic signed [COEF_W-1:0]  in_accel = '0;
  logic signed [COEF_W-1:0]  in_velocity = '0;
  logic signed [COEF_W-1:0]  in_position = '0;
  logic [TIME_W-1:0]         in_query_time = '0;
  logic                      out_valid;
  logic signed [COEF_W-1:0]  out_pos_x;
  logic signed [COEF_W-1:0]  out_pos_y;
  logic signed [COEF_W-1:0]  out_pos_z;
  logic [SEG_W-1:0]          out_segment_used;
  logic                      out_extrapolated;

  // predictor state
  logic [TIME_W-1:0]         seg_t0 [MAX_SEGMENTS];
  logic [TIME_W-1:0]         seg_t1 [MAX_SEGMENTS];
  logic signed [COEF_W-1:0]  coef [MAX_SEGMENTS][AXES][3];
  logic [CFG_W-1:0]          seg_count = 5'd1;

  // planned segment times used to build well-formed tables
  logic [TIME_W-1:0]         plan_t0 [MAX_SEGMENTS];
  logic [TIME_W-1:0]         plan_t1 [MAX_SEGMENTS];

  traj_item_t                item_q [$];
  traj_point_t               point_q [$];

  bit                        took = 1'b0;
  int                        gap_left = 0;
  int                        idle_pct = 20;
  int                        idle_run = 0;
  int                        n_errors = 0;
  int                        n_loads = 0;
  int                        n_queries = 0;
  int                        n_results = 0;
  int                        n_extra = 0;
  int                        n_sat = 0;
  int                        n_settings = 0;
  logic [MAX_SEGMENTS-1:0]   seg_hit = '0;

  logic [CFG_W-1:0] cfg_plan [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd1, 5'd9, 5'd12};

  piecewise_trajectory_eval_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_seg_index     (in_seg_index),
    .in_axis          (in_axis),
    .in_start_time    (in_start_time),
    .in_end_time      (in_end_time),
    .in_accel         (in_accel),
    .in_velocity      (in_velocity),
    .in_position      (in_position),
    .in_query_time    (in_query_time),
    .out_valid        (out_valid),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_segment_used (out_segment_used),
    .out_extrapolated (out_extrapolated)
  );

  always #1 clk = ~clk;

  function automatic logic [TIME_W-1:0] rand_t();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic traj_item_t mk_load(input logic [SEG_W-1:0] slot,
                                         input logic [AX_W-1:0] ax,
                                         input logic [TIME_W-1:0] t0, t1,
                                         input logic signed [COEF_W-1:0] a, v, p);
    traj_item_t it;
    it = '{op: OP_LOAD, slot: slot, ax: ax, t0: t0, t1: t1, acc: a, vel: v, pos: p,
           qt: rand_t(), drain: 1'b0};
    return it;
  endfunction

  function automatic traj_item_t mk_query(input logic [TIME_W-1:0] qt, input logic drain);
    traj_item_t it;
    it = '{op: OP_QUERY, slot: SEG_W'($urandom), ax: AX_W'($urandom), t0: rand_t(),
           t1: rand_t(), acc: $urandom, vel: $urandom, pos: $urandom, qt: qt,
           drain: drain};
    return it;
  endfunction

  // exact P + V*dt + A*dt^2/2 in units of 2^-33, round half up, saturate
  function automatic logic signed [COEF_W-1:0] axis_pos(input logic signed [COEF_W-1:0] a, v, p,
                                                        input logic signed [COEF_W-1:0] dt);
    logic signed [127:0] aw, vw, pw, dw, sum;
    aw = a;
    vw = v;
    pw = p;
    dw = dt;
    sum = (pw <<< 33) + ((vw * dw) <<< 17) + aw * dw * dw + (128'sd1 <<< 32);
    sum = sum >>> 33;
    if (sum > 128'sd2147483647) return COEF_MAX;
    if (sum < -128'sd2147483648) return COEF_MIN;
    return sum[COEF_W-1:0];
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      n_errors++;
      $error("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  // append one item to the pending queue
  task automatic add_item(input traj_item_t it);
    item_q.insert(item_q.size(), it);
  endtask

  task automatic draw_plan();
    logic [TIME_W-1:0] t;
    case ($urandom_range(0, 2))
      0: t = TIME_W'($urandom_range(32'h0001_0000, 32'h0010_0000));
      1: t = TIME_W'($urandom);
      default: t = {16'hFFF0, 32'h0} + TIME_W'($urandom);
    endcase
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      plan_t0[i] = t;
      plan_t1[i] = t + TIME_W'($urandom_range(0, 32'h0010_0000));
      t = plan_t1[i] + TIME_W'($urandom_range(0, 32'h0001_0000));
    end
  endtask

  // rewrite every slot and axis, so no query can reach an unwritten entry
  task automatic refill();
    for (int s = 0; s < MAX_SEGMENTS; s++)
      for (int x = 0; x < AXES; x++)
        add_item(mk_load(SEG_W'(s), AX_W'(x), plan_t0[s], plan_t1[s],
                         rand_coef(), rand_coef(), rand_coef()));
  endtask

  // block is idle once every item went in and every result came out
  task automatic settle();
    do @(negedge clk); while (item_q.size() != 0 || start || point_q.size() != 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_segments(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // driver
  always @(negedge clk) begin
    traj_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (took && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap_left <= $urandom_range(0, 16);
        start <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (item_q.size() != 0 && !(item_q[0].drain && point_q.size() != 0)) begin
        it = item_q.pop_front();
        in_operation  <= it.op;
        in_seg_index  <= it.slot;
        in_axis       <= it.ax;
        in_start_time <= it.t0;
        in_end_time   <= it.t1;
        in_accel      <= it.acc;
        in_velocity   <= it.vel;
        in_position   <= it.pos;
        in_query_time <= it.qt;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    traj_point_t want;
    logic signed [TIME_W+1:0] diff;
    logic signed [COEF_W-1:0] dt;
    logic [SEG_W-1:0] sel;
    logic hit;
    int n_use;
    took <= rst_n && start && !busy;
    if (!rst_n) begin
      seg_count <= 5'd1;
    end else begin
      if (cfg_we) seg_count <= cfg_wdata;

      if (start && !busy) begin
        if (in_operation == OP_LOAD) begin
          n_loads++;
          if (in_axis != AX_NONE) begin
            seg_t0[in_seg_index] = in_start_time;
            seg_t1[in_seg_index] = in_end_time;
            coef[in_seg_index][in_axis][C_ACC] = in_accel;
            coef[in_seg_index][in_axis][C_VEL] = in_velocity;
            coef[in_seg_index][in_axis][C_POS] = in_position;
          end
        end else begin
          n_queries++;
          n_use = (seg_count == 0) ? 1 :
                  (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
          sel = SEG_W'(n_use - 1);
          hit = 1'b0;
          for (int i = 0; i < n_use; i++)
            if (!hit && in_query_time <= seg_t1[i]) begin
              sel = SEG_W'(i);
              hit = 1'b1;
            end
          diff = $signed({2'b00, in_query_time}) - $signed({2'b00, seg_t0[sel]});
          if (diff > 50'sd2147483647) dt = COEF_MAX;
          else if (diff < -50'sd2147483648) dt = COEF_MIN;
          else dt = diff[COEF_W-1:0];
          want.px = axis_pos(coef[sel][0][C_ACC], coef[sel][0][C_VEL], coef[sel][0][C_POS], dt);
          want.py = axis_pos(coef[sel][1][C_ACC], coef[sel][1][C_VEL], coef[sel][1][C_POS], dt);
          want.pz = axis_pos(coef[sel][2][C_ACC], coef[sel][2][C_VEL], coef[sel][2][C_POS], dt);
          want.seg = sel;
          want.extra = !hit;
          point_q.insert(point_q.size(), want);
        end
      end

      if (out_valid) begin
        if (point_q.size() == 0) begin
          n_errors++;
          $error("result strobe with no query outstanding");
        end else begin
          want = point_q.pop_front();
          check_field("pos_x", want.px, out_pos_x);
          check_field("pos_y", want.py, out_pos_y);
          check_field("pos_z", want.pz, out_pos_z);
          check_field("segment_used", 32'(want.seg), 32'(out_segment_used));
          check_field("extrapolated", 32'(want.extra), 32'(out_extrapolated));
          n_results++;
          seg_hit[want.seg] = 1'b1;
          if (want.extra) n_extra++;
          if (want.px == COEF_MAX || want.px == COEF_MIN || want.py == COEF_MAX ||
              want.py == COEF_MIN || want.pz == COEF_MAX || want.pz == COEF_MIN)
            n_sat++;
        end
      end

      if ((start && !busy) || out_valid) begin
        idle_run <= 0;
      end else if (idle_run == WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // stimulus
  initial begin
    int r;
    int k;
    int ne;
    logic [TIME_W-1:0] qt;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [AX_W-1:0] ax;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // table fill, then a couple of queries at the reset segment count of one
    draw_plan();
    plan_t0[0] = plan_t0[0] | TIME_W'(32'h0001_0000);
    if (plan_t1[0] < plan_t0[0]) plan_t1[0] = plan_t0[0];
    @(posedge clk);
    refill();
    add_item(mk_query('0, 1'b0));
    add_item(mk_query(TIME_MAX, 1'b0));
    settle();

    set_segments(5'd16);
    @(posedge clk);
    add_item(mk_query(plan_t1[7], 1'b0));
    add_item(mk_query(plan_t1[7] + 1, 1'b0));
    add_item(mk_query(plan_t1[15] + 1, 1'b0));
    add_item(mk_query(plan_t0[4], 1'b0));
    // bad axis: must leave slot 3 alone
    add_item(mk_load(4'd3, AX_NONE, TIME_MAX, TIME_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
    add_item(mk_query(plan_t1[3], 1'b0));
    add_item(mk_load(4'd0, AX_X, '0, plan_t1[0], COEF_MAX, COEF_MAX, COEF_MAX));
    add_item(mk_load(4'd0, AX_Y, '0, plan_t1[0], COEF_MIN, COEF_MIN, COEF_MIN));
    add_item(mk_load(4'd0, AX_Z, '0, plan_t1[0], COEF_MAX, COEF_MIN, '0));
    add_item(mk_query(plan_t1[0], 1'b0));
    // slot 15 starts at the top of the time range: large negative dt
    add_item(mk_load(4'd15, AX_X, TIME_MAX, TIME_MAX, COEF_MIN, COEF_MAX, COEF_MIN));
    add_item(mk_query(TIME_MAX, 1'b0));
    add_item(mk_query(plan_t1[15] + 5, 1'b0));
    add_item(mk_query('0, 1'b1));
    add_item(mk_load(4'd0, AX_X, plan_t0[0], plan_t1[0], 32'sd1, -32'sd1, '0));
    add_item(mk_query(plan_t0[0] >> 1, 1'b0));
    add_item(mk_query(plan_t0[0], 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      set_segments(cfg_plan[ph]);
      ne = (cfg_plan[ph] == 0) ? 1 :
           (cfg_plan[ph] > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(cfg_plan[ph]);
      @(posedge clk);
      idle_pct = (ph == PHASES - 1 || ph % 3 == 2) ? 0 : $urandom_range(5, 40);
      draw_plan();
      refill();
      repeat (RANDOM_ITEMS) begin
        r = $urandom_range(0, 99);
        k = $urandom_range(0, ne - 1);
        if (r < 30) begin
          ax = ($urandom_range(0, 15) == 0) ? AX_NONE : AX_W'($urandom_range(0, 2));
          k = $urandom_range(0, MAX_SEGMENTS - 1);
          t0 = plan_t0[k];
          t1 = plan_t1[k];
          if ($urandom_range(0, 19) == 0) begin
            t0 = rand_t();
            t1 = rand_t();
          end
          add_item(mk_load(SEG_W'(k), ax, t0, t1, rand_coef(), rand_coef(), rand_coef()));
        end else begin
          r = $urandom_range(0, 19);
          if (r < 10)
            qt = plan_t1[k] + TIME_W'($urandom_range(0, 2)) - 1;
          else if (r < 15)
            qt = plan_t0[k] + TIME_W'($urandom_range(0, 32'(plan_t1[k] - plan_t0[k])));
          else if (r < 17)
            qt = plan_t1[ne-1] + TIME_W'($urandom_range(1, 32'h0010_0000));
          else if (r == 17)
            qt = plan_t0[k] - TIME_W'($urandom_range(0, 32'h0010_0000));
          else if (r == 18)
            qt = $urandom_range(0, 1) ? TIME_MAX : '0;
          else
            qt = rand_t();
          add_item(mk_query(qt, $urandom_range(0, 39) == 0));
        end
      end
    end
    settle();

    $display("covered %0d loads and %0d queries over %0d segment-count settings",
             n_loads, n_queries, n_settings);
    $display("%0d results checked: %0d extrapolated, %0d saturated, %0d of %0d slots evaluated",
             n_results, n_extra, n_sat, $countones(seg_hit), MAX_SEGMENTS);
    if (n_errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/ptev_pkg.sv
hdl/ptev_seg_table.sv
hdl/ptev_mac.sv
hdl/piecewise_trajectory_eval_unit.sv
tb/testbench.sv
